>>> hdl/qrs_pkg.sv
// Package for the quadratic root solver: widths, class codes and shared types.
// Used by the channel interfaces and by every module of the block but the queue.
package qrs_pkg;

	localparam int COEF_W = 16;
	localparam int FRAC_W = 16;
	localparam int ROOT_W = 32;
	localparam int KIND_W = 3;

	typedef enum logic [KIND_W-1:0] {
		KIND_INVALID  = 3'd0,
		KIND_NONE     = 3'd1,
		KIND_LINEAR   = 3'd2,
		KIND_COMPLEX  = 3'd3,
		KIND_DOUBLE   = 3'd4,
		KIND_TWO_REAL = 3'd5
	} kind_t;

endpackage

>>> hdl/qrs_coef_if.sv
// Channel that carries one coefficient set from a source to a sink.
// Depends on qrs_pkg.
interface qrs_coef_if import qrs_pkg::*; #(parameter int CW = COEF_W);
	logic valid;
	logic ready;
	logic signed [CW-1:0] coef_a;
	logic signed [CW-1:0] coef_b;
	logic signed [CW-1:0] coef_c;
	modport source (output valid, coef_a, coef_b, coef_c, input ready);
	modport sink (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

>>> hdl/qrs_root_if.sv
// Channel that carries one classified result from a source to a sink.
// Depends on qrs_pkg.
interface qrs_root_if import qrs_pkg::*;;
	logic valid;
	logic ready;
	logic [KIND_W-1:0] kind;
	logic signed [ROOT_W-1:0] root_one;
	logic signed [ROOT_W-1:0] root_two;
	logic saturated;
	modport source (output valid, kind, root_one, root_two, saturated, input ready);
	modport sink (input valid, kind, root_one, root_two, saturated, output ready);
endinterface

>>> hdl/qrs_front.sv
// Front end: classifies the equation and computes the discriminant magnitude.
// Depends on qrs_pkg.
module qrs_front import qrs_pkg::*; #(
	parameter int CW = COEF_W
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [CW-1:0] a_in,
	input  logic signed [CW-1:0] b_in,
	input  logic signed [CW-1:0] c_in,
	output logic out_valid,
	input  logic out_ready,
	output kind_t kind,
	output logic signed [CW:0] nb,
	output logic signed [CW+1:0] den,
	output logic [2*CW+2:0] mag,
	output logic signed [CW-1:0] c_out,
	output logic signed [CW-1:0] b_out
);
	logic v_s1, v_s2;
	logic adv_s1, adv_s2;
	logic signed [CW-1:0] a_s1, b_s1, c_s1, b_s2, c_s2;
	logic signed [2*CW-1:0] bb_s1;
	logic signed [2*CW+1:0] ac4_s1;
	logic signed [2*CW-1:0] ac_full;
	logic signed [2*CW+2:0] d;
	kind_t kind_s2;
	logic signed [CW:0] nb_s2;
	logic signed [CW+1:0] den_s2;
	logic [2*CW+2:0] mag_s2;

	// Two stages: products, then discriminant and class.
	assign adv_s2 = !v_s2 || out_ready;
	assign adv_s1 = !v_s1 || adv_s2;
	assign in_ready = adv_s1;
	assign ac_full = a_in * c_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= in_valid;
			if (adv_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			a_s1 <= a_in;
			b_s1 <= b_in;
			c_s1 <= c_in;
			bb_s1 <= b_in * b_in;
			ac4_s1 <= {ac_full, 2'b00};
		end
	end

	assign d = {bb_s1[2*CW-1], bb_s1} - {ac4_s1[2*CW+1], ac4_s1};

	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			b_s2 <= b_s1;
			c_s2 <= c_s1;
			nb_s2 <= -{b_s1[CW-1], b_s1};
			den_s2 <= {a_s1[CW-1], a_s1, 1'b0};
			mag_s2 <= d[2*CW+2] ? -d : d;
			if (a_s1 == '0 && b_s1 == '0 && c_s1 == '0) kind_s2 <= KIND_INVALID;
			else if (a_s1 == '0 && b_s1 == '0) kind_s2 <= KIND_NONE;
			else if (a_s1 == '0) kind_s2 <= KIND_LINEAR;
			else if (d[2*CW+2]) kind_s2 <= KIND_COMPLEX;
			else if (d == '0) kind_s2 <= KIND_DOUBLE;
			else kind_s2 <= KIND_TWO_REAL;
		end
	end

	assign out_valid = v_s2;
	assign kind = kind_s2;
	assign nb = nb_s2;
	assign den = den_s2;
	assign mag = mag_s2;
	assign c_out = c_s2;
	assign b_out = b_s2;
endmodule

>>> hdl/qrs_queue.sv
// Short queue that decouples the front end from the back end.
// Depends only on its parameters.
module qrs_queue #(
	parameter int W = 8,
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [W-1:0] in_data,
	output logic out_valid,
	input  logic out_ready,
	output logic [W-1:0] out_data
);
	localparam int AW = $clog2(DEPTH);
	logic [W-1:0] mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;
	logic wr, rd;

	assign in_ready = cnt_q != (AW+1)'(DEPTH);
	assign out_valid = cnt_q != '0;
	assign wr = in_valid && in_ready;
	assign rd = out_valid && out_ready;
	assign out_data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (rd) rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= in_data;
	end
endmodule

>>> hdl/qrs_back.sv
// Back end: pipelined square root, pipelined dividers and saturation.
// Depends on qrs_pkg.
module qrs_back import qrs_pkg::*; #(
	parameter int CW = COEF_W,
	parameter int FW = FRAC_W
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  kind_t kind,
	input  logic signed [CW:0] nb,
	input  logic signed [CW+1:0] den,
	input  logic [2*CW+2:0] mag,
	input  logic signed [CW-1:0] c_in,
	input  logic signed [CW-1:0] b_in,
	qrs_root_if.source res
);
	localparam int MW = 2*CW + 3 + 2*FW;
	localparam int SW = (MW + 1) / 2;
	localparam int NW = CW + 1 + FW + 2;
	localparam int QW = NW;
	localparam int DW = CW + 2;
	localparam int SQ = SW;
	localparam int DV = QW;
	localparam int NS = SQ + DV + 2;

	logic [NS:0] v_q;
	logic adv;

	// Square root: one result bit per stage.
	logic [MW-1:0] sq_rem [SQ+1];
	logic [SW-1:0] sq_res [SQ+1];
	kind_t sq_k [SQ+1];
	logic signed [CW:0] sq_nb [SQ+1];
	logic signed [CW+1:0] sq_den [SQ+1];
	logic signed [CW-1:0] sq_c [SQ+1];
	logic signed [CW-1:0] sq_b [SQ+1];

	assign adv = !res.valid || res.ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else if (adv) v_q <= {v_q[NS-1:0], in_valid};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_rem[0] <= {mag, {(2*FW){1'b0}}};
			sq_res[0] <= '0;
			sq_k[0] <= kind;
			sq_nb[0] <= nb;
			sq_den[0] <= den;
			sq_c[0] <= c_in;
			sq_b[0] <= b_in;
		end
	end

	genvar g;
	generate
		for (g = 0; g < SQ; g++) begin : g_sq
			localparam int BI = SW - 1 - g;
			logic [SW-1:0] cand;
			logic [2*SW-1:0] csq;
			assign cand = sq_res[g] | (SW'(1) << BI);
			assign csq = cand * cand;
			always_ff @(posedge clk) begin
				if (adv) begin
					sq_rem[g+1] <= sq_rem[g];
					sq_res[g+1] <= ((2*SW > MW ? csq : (2*SW)'(csq)) <= (2*SW)'(sq_rem[g]))
						? cand : sq_res[g];
					sq_k[g+1] <= sq_k[g];
					sq_nb[g+1] <= sq_nb[g];
					sq_den[g+1] <= sq_den[g];
					sq_c[g+1] <= sq_c[g];
					sq_b[g+1] <= sq_b[g];
				end
			end
		end
	endgenerate

	// Build numerators and divisor magnitudes.
	logic [SW-1:0] s;
	logic signed [NW-1:0] nbs, n1, n2, nlin;
	logic [QW-1:0] u1, u2;
	logic [DW-1:0] dmag;
	logic neg1, neg2;
	kind_t kk;

	assign s = sq_res[SQ];
	assign kk = sq_k[SQ];
	assign nbs = NW'(sq_nb[SQ]) <<< FW;
	assign nlin = -(NW'(sq_c[SQ]) <<< FW);

	always_comb begin
		n1 = nbs;
		n2 = nbs;
		dmag = sq_den[SQ][CW+1] ? DW'(-sq_den[SQ]) : DW'(sq_den[SQ]);
		neg1 = 1'b0;
		neg2 = 1'b0;
		case (kk)
			KIND_LINEAR: begin
				n1 = nlin;
				n2 = '0;
				dmag = sq_b[SQ][CW-1] ? DW'(-DW'(sq_b[SQ])) : DW'(sq_b[SQ]);
				neg1 = nlin[NW-1] ^ sq_b[SQ][CW-1];
			end
			KIND_COMPLEX: begin
				n2 = NW'(s);
				neg1 = nbs[NW-1] ^ sq_den[SQ][CW+1];
			end
			KIND_TWO_REAL: begin
				n1 = nbs + NW'(s);
				n2 = nbs - NW'(s);
				neg1 = n1[NW-1] ^ sq_den[SQ][CW+1];
				neg2 = n2[NW-1] ^ sq_den[SQ][CW+1];
			end
			default: begin
				neg1 = nbs[NW-1] ^ sq_den[SQ][CW+1];
				neg2 = neg1;
			end
		endcase
		u1 = n1[NW-1] ? QW'(-n1) : QW'(n1);
		u2 = n2[NW-1] ? QW'(-n2) : QW'(n2);
	end

	// Restoring division of two magnitudes, one quotient bit per stage.
	logic [QW-1:0] q1 [DV+1], q2 [DV+1];
	logic [DW:0] r1 [DV+1], r2 [DV+1];
	logic [QW-1:0] x1 [DV+1], x2 [DV+1];
	logic [DW-1:0] dv [DV+1];
	logic ng1 [DV+1], ng2 [DV+1];
	kind_t dk [DV+1];

	always_ff @(posedge clk) begin
		if (adv) begin
			q1[0] <= '0; q2[0] <= '0;
			r1[0] <= '0; r2[0] <= '0;
			x1[0] <= u1; x2[0] <= u2;
			dv[0] <= dmag;
			ng1[0] <= neg1; ng2[0] <= neg2;
			dk[0] <= kk;
		end
	end

	generate
		for (g = 0; g < DV; g++) begin : g_dv
			logic [DW:0] t1, t2;
			assign t1 = {r1[g][DW-1:0], x1[g][QW-1]};
			assign t2 = {r2[g][DW-1:0], x2[g][QW-1]};
			always_ff @(posedge clk) begin
				if (adv) begin
					r1[g+1] <= (t1 >= {1'b0, dv[g]}) ? t1 - {1'b0, dv[g]} : t1;
					r2[g+1] <= (t2 >= {1'b0, dv[g]}) ? t2 - {1'b0, dv[g]} : t2;
					q1[g+1] <= {q1[g][QW-2:0], t1 >= {1'b0, dv[g]}};
					q2[g+1] <= {q2[g][QW-2:0], t2 >= {1'b0, dv[g]}};
					x1[g+1] <= x1[g] << 1;
					x2[g+1] <= x2[g] << 1;
					dv[g+1] <= dv[g];
					ng1[g+1] <= ng1[g];
					ng2[g+1] <= ng2[g];
					dk[g+1] <= dk[g];
				end
			end
		end
	endgenerate

	// Sign, saturate and register the result.
	localparam logic [QW:0] PMAX = (QW+1)'(33'h0_7FFF_FFFF);
	logic [QW-1:0] fq1, fq2;
	logic signed [ROOT_W-1:0] o1, o2;
	logic sat1, sat2;
	kind_t fk;

	assign fq1 = q1[DV];
	assign fq2 = q2[DV];
	assign fk = dk[DV];

	always_comb begin
		sat1 = 1'b0;
		sat2 = 1'b0;
		if (ng1[DV]) begin
			if ({1'b0, fq1} > PMAX + 1'b1) begin
				o1 = {1'b1, {(ROOT_W-1){1'b0}}}; sat1 = 1'b1;
			end else o1 = -ROOT_W'(fq1);
		end else begin
			if ({1'b0, fq1} > PMAX) begin
				o1 = {1'b0, {(ROOT_W-1){1'b1}}}; sat1 = 1'b1;
			end else o1 = ROOT_W'(fq1);
		end
		if (ng2[DV] && fk != KIND_COMPLEX) begin
			if ({1'b0, fq2} > PMAX + 1'b1) begin
				o2 = {1'b1, {(ROOT_W-1){1'b0}}}; sat2 = 1'b1;
			end else o2 = -ROOT_W'(fq2);
		end else begin
			if ({1'b0, fq2} > PMAX) begin
				o2 = {1'b0, {(ROOT_W-1){1'b1}}}; sat2 = 1'b1;
			end else o2 = ROOT_W'(fq2);
		end
	end

	logic [KIND_W-1:0] k_q;
	logic signed [ROOT_W-1:0] o1_q, o2_q;
	logic sat_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			k_q <= fk;
			sat_q <= 1'b0;
			o1_q <= '0;
			o2_q <= '0;
			case (fk)
				KIND_LINEAR: begin
					o1_q <= o1; sat_q <= sat1;
				end
				KIND_COMPLEX, KIND_TWO_REAL: begin
					o1_q <= o1; o2_q <= o2; sat_q <= sat1 | sat2;
				end
				KIND_DOUBLE: begin
					o1_q <= o1; o2_q <= o1; sat_q <= sat1;
				end
				default: ;
			endcase
		end
	end

	assign res.valid = v_q[NS];
	assign res.kind = k_q;
	assign res.root_one = o1_q;
	assign res.root_two = o2_q;
	assign res.saturated = sat_q;
endmodule

>>> hdl/quadratic_root_solver.sv
// Top level of the quadratic root solver: front end, queue and back end.
// Depends on qrs_pkg, qrs_coef_if, qrs_root_if, qrs_front, qrs_queue, qrs_back.
//
// Usage: coefficient sets enter on the coef channel (coef_a, coef_b, coef_c,
// signed Q8.8) and one result per set leaves on the root channel (kind,
// root_one, root_two in signed Q16.16, saturated). A transfer happens when
// valid and ready are both high.
// The block accepts one set per cycle while ready is high. A set passes the two
// front stages, the queue, the square root of COEF_WIDTH+ROOT_FRAC_BITS+3 stages
// with its input register, the divider of COEF_WIDTH+ROOT_FRAC_BITS+4 stages with
// its input register and one output register.
// When the receiver stalls, the back end pipeline holds, the queue fills and
// then the front end drops ready. Reset empties every stage and the queue;
// no result is pending after reset.
module quadratic_root_solver import qrs_pkg::*; #(
	parameter int COEF_WIDTH = COEF_W,
	parameter int ROOT_FRAC_BITS = FRAC_W
) (
	input  logic clk,
	input  logic arst_n,
	qrs_coef_if.sink coef,
	qrs_root_if.source root
);
	localparam int CW = COEF_WIDTH;
	localparam int QDW = KIND_W + (CW+1) + (CW+2) + (2*CW+3) + 2*CW;

	logic fv, fr, qv, qr;
	kind_t fk;
	logic signed [CW:0] fnb;
	logic signed [CW+1:0] fden;
	logic [2*CW+2:0] fmag;
	logic signed [CW-1:0] fc, fb;
	logic [QDW-1:0] qin, qout;

	qrs_front #(.CW(CW)) u_front (
		.clk, .arst_n,
		.in_valid(coef.valid), .in_ready(coef.ready),
		.a_in(coef.coef_a), .b_in(coef.coef_b), .c_in(coef.coef_c),
		.out_valid(fv), .out_ready(fr),
		.kind(fk), .nb(fnb), .den(fden), .mag(fmag), .c_out(fc), .b_out(fb)
	);

	assign qin = {fk, fnb, fden, fmag, fc, fb};

	qrs_queue #(.W(QDW), .DEPTH(4)) u_queue (
		.clk, .arst_n,
		.in_valid(fv), .in_ready(fr), .in_data(qin),
		.out_valid(qv), .out_ready(qr), .out_data(qout)
	);

	qrs_back #(.CW(CW), .FW(ROOT_FRAC_BITS)) u_back (
		.clk, .arst_n,
		.in_valid(qv), .in_ready(qr),
		.kind(kind_t'(qout[QDW-1 -: KIND_W])),
		.nb(qout[QDW-KIND_W-1 -: CW+1]),
		.den(qout[QDW-KIND_W-CW-2 -: CW+2]),
		.mag(qout[4*CW-1+3 -: 2*CW+3]),
		.c_in(qout[2*CW-1 -: CW]),
		.b_in(qout[CW-1:0]),
		.res(root)
	);
endmodule

>>> dv/tb_quadratic_root_solver.sv
// Self-checking testbench for the quadratic root solver: drives coefficient sets,
// predicts class and roots with exact wide integer arithmetic, and checks each result.
// Depends on qrs_pkg, qrs_coef_if, qrs_root_if and quadratic_root_solver.
class root_scoreboard;
	typedef struct {
		qrs_pkg::kind_t kind;
		logic signed [31:0] root_one;
		logic signed [31:0] root_two;
		logic saturated;
	} root_t;

	root_t pending[$];
	int errors;

	function automatic logic signed [31:0] clip(longint v, ref logic flag);
		if (v > 64'sd2147483647) begin
			flag = 1'b1;
			return 32'sh7fffffff;
		end
		if (v < -64'sd2147483648) begin
			flag = 1'b1;
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	function automatic logic [63:0] isqrt(logic [127:0] m);
		logic [63:0] r;
		logic [63:0] cand;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			cand = r | (64'd1 << i);
			if ({64'd0, cand} * {64'd0, cand} <= m)
				r = cand;
		end
		return r;
	endfunction

	function void note_coefs(logic signed [15:0] ca, logic signed [15:0] cb,
			logic signed [15:0] cc);
		root_t r;
		longint a, b, c, nb, den;
		logic signed [127:0] disc;
		logic [127:0] mag;
		logic [63:0] s, im;
		logic flag;
		a = ca;
		b = cb;
		c = cc;
		flag = 1'b0;
		r.kind = qrs_pkg::KIND_INVALID;
		r.root_one = '0;
		r.root_two = '0;
		if (a == 0 && b == 0 && c == 0) begin
			r.kind = qrs_pkg::KIND_INVALID;
		end else if (a == 0 && b == 0) begin
			r.kind = qrs_pkg::KIND_NONE;
		end else if (a == 0) begin
			r.kind = qrs_pkg::KIND_LINEAR;
			r.root_one = clip((-c * 65536) / b, flag);
		end else begin
			nb = -b * 65536;
			den = 2 * a;
			disc = 128'(b * b) - 128'(4 * a * c);
			mag = disc < 0 ? -disc : disc;
			s = isqrt(mag << 32);
			if (disc < 0) begin
				r.kind = qrs_pkg::KIND_COMPLEX;
				r.root_one = clip(nb / den, flag);
				im = s / 64'(den < 0 ? -den : den);
				if (im > 64'd2147483647) begin
					im = 64'd2147483647;
					flag = 1'b1;
				end
				r.root_two = im[31:0];
			end else if (disc == 0) begin
				r.kind = qrs_pkg::KIND_DOUBLE;
				r.root_one = clip(nb / den, flag);
				r.root_two = r.root_one;
			end else begin
				r.kind = qrs_pkg::KIND_TWO_REAL;
				r.root_one = clip((nb + longint'(s)) / den, flag);
				r.root_two = clip((nb - longint'(s)) / den, flag);
			end
		end
		r.saturated = flag;
		pending.push_back(r);
	endfunction

	task report(string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	task check_result(logic [2:0] kind, logic signed [31:0] r1, logic signed [31:0] r2,
			logic sat);
		root_t e;
		if (pending.size() == 0) begin
			report("result with nothing expected");
			return;
		end
		e = pending.pop_front();
		if (kind !== e.kind)
			report($sformatf("kind %0d, expected %0d", kind, e.kind));
		if (r1 !== e.root_one)
			report($sformatf("root_one %0d, expected %0d", r1, e.root_one));
		if (r2 !== e.root_two)
			report($sformatf("root_two %0d, expected %0d", r2, e.root_two));
		if (sat !== e.saturated)
			report($sformatf("saturated %0b, expected %0b", sat, e.saturated));
	endtask
endclass

module tb_quadratic_root_solver;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;
	root_scoreboard board = new();

	qrs_coef_if coef_ch ();
	qrs_root_if root_ch ();

	quadratic_root_solver dut (
		.clk(clk),
		.arst_n(arst_n),
		.coef(coef_ch.sink),
		.root(root_ch.source)
	);

	always #1 clk = ~clk;

	initial begin
		coef_ch.valid = 1'b0;
		coef_ch.coef_a = '0;
		coef_ch.coef_b = '0;
		coef_ch.coef_c = '0;
		root_ch.ready = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n)
			root_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (root_ch.valid && root_ch.ready)
			board.check_result(root_ch.kind, root_ch.root_one, root_ch.root_two,
				root_ch.saturated);
		if ((coef_ch.valid && coef_ch.ready) || (root_ch.valid && root_ch.ready))
			quiet_cycles = 0;
		else if (arst_n)
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task send_coefs(logic signed [15:0] a, logic signed [15:0] b, logic signed [15:0] c);
		while ($urandom_range(99) < send_idle_pct) begin
			coef_ch.valid <= 1'b0;
			@(posedge clk);
		end
		coef_ch.valid <= 1'b1;
		coef_ch.coef_a <= a;
		coef_ch.coef_b <= b;
		coef_ch.coef_c <= c;
		do
			@(posedge clk);
		while (!coef_ch.ready);
		board.note_coefs(a, b, c);
	endtask

	function automatic logic [15:0] pick_coef();
		case ($urandom_range(5))
			0: return 16'($urandom_range(7)) - 16'd3;
			1: return 16'h8000 + 16'($urandom_range(3));
			2: return 16'h7fff - 16'($urandom_range(3));
			3: return 16'($urandom_range(511)) - 16'd256;
			default: return 16'($urandom);
		endcase
	endfunction

	task send_random(int count);
		logic signed [15:0] a, b, c;
		int r;
		for (int i = 0; i < count; i++) begin
			a = pick_coef();
			b = pick_coef();
			c = pick_coef();
			r = $urandom_range(9);
			if (r == 0)
				a = '0;
			if (r == 1) begin
				a = '0;
				b = '0;
			end
			if (r == 2)
				c = 16'((b * b) / (4 * ((a == 0) ? 16'sd1 : a)));
			if (r == 3) begin
				a = 16'sd256 * $signed(16'($urandom_range(3)) + 16'sd1);
				b = 16'(a * 2);
				c = a;
			end
			send_coefs(a, b, c);
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_coefs(16'sd0, 16'sd0, 16'sd0);
		send_coefs(16'sd0, 16'sd0, 16'sh7fff);
		send_coefs(16'sd0, 16'sd0, -16'sd32768);
		send_coefs(16'sd0, 16'sd1, -16'sd32768);
		send_coefs(16'sd0, -16'sd1, 16'sh7fff);
		send_coefs(16'sd0, 16'sh7fff, 16'sd1);
		send_coefs(16'sd0, -16'sd32768, -16'sd32768);
		send_coefs(16'sd256, 16'sd0, 16'sd256);
		send_coefs(16'sd1, 16'sd0, 16'sh7fff);
		send_coefs(-16'sd1, 16'sd0, 16'sh7fff);
		send_coefs(16'sd256, 16'sd512, 16'sd256);
		send_coefs(-16'sd32768, -16'sd32768, -16'sd8192);
		send_coefs(16'sd256, 16'sd0, -16'sd256);
		send_coefs(16'sd1, -16'sd32768, 16'sd0);
		send_coefs(16'sd1, 16'sh7fff, -16'sd32768);
		send_coefs(-16'sd32768, 16'sh7fff, 16'sh7fff);
		send_coefs(16'sh7fff, 16'sd1, 16'sh7fff);
		send_coefs(-16'sd1, -16'sd32768, -16'sd32768);
		send_coefs(16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_coefs(-16'sd32768, -16'sd32768, -16'sd32768);
		send_coefs(16'sh5555, 16'shaaaa, 16'sh5555);
		send_random(150);
		send_idle_pct = 60;
		send_random(150);
		send_idle_pct = 0;
		recv_stall_pct = 60;
		send_random(150);
		send_idle_pct = 12;
		recv_stall_pct = 12;
		send_random(150);
		coef_ch.valid <= 1'b0;
		wait (board.pending.size() == 0);
		repeat (100) @(posedge clk);
		if (board.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
